[hw/rtl/hbtm_pkg.sv]
// Shared types and constants for the heartbeat timeout monitor.
`default_nettype none

package hbtm_pkg;

    // Fixed number of channels that have configuration registers
    localparam int REG_CHANNELS = 4;

    localparam int TIME_W  = 32;
    localparam int LEVEL_W = 2;
    localparam int CHAN_W  = 3;
    localparam int CIDX_W  = 4;
    localparam int CDATA_W = 32;

    // Input opcodes
    localparam logic OP_HEARTBEAT = 1'b0;
    localparam logic OP_CHECK     = 1'b1;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ENABLE_MASK    = 4'd0;
    localparam logic [CIDX_W-1:0] CFG_CHANNEL_LEVELS = 4'd1;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT_ONE    = 4'd2;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT_TWO    = 4'd3;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT_THREE  = 4'd4;
    localparam logic [CIDX_W-1:0] CFG_TIMEOUT_FOUR   = 4'd5;
    localparam logic [CIDX_W-1:0] CFG_WARNING_LEVEL  = 4'd6;
    localparam logic [CIDX_W-1:0] CFG_FATAL_LEVEL    = 4'd7;

    // Register reset values
    localparam logic [4:0]        RST_ENABLE_MASK    = 5'd0;
    localparam logic [7:0]        RST_CHANNEL_LEVELS = 8'd85;
    localparam logic [TIME_W-1:0] RST_TIMEOUT        = 32'd1000;
    localparam logic [1:0]        RST_WARNING_LEVEL  = 2'd1;
    localparam logic [1:0]        RST_FATAL_LEVEL    = 2'd0;

    // Worst level code when no channel is offline
    localparam logic [2:0] LEVEL_NONE = 3'd4;

    typedef logic [REG_CHANNELS-1:0][TIME_W-1:0] time_vec_t;

    // Configuration registers as seen by the evaluator
    typedef struct packed {
        logic [4:0]        enable_mask;
        logic [7:0]        channel_levels;
        time_vec_t         timeouts;
        logic [1:0]        warning_level;
        logic [1:0]        fatal_level;
    } cfg_t;

    // One check result word
    typedef struct packed {
        logic [3:0] offline_mask;
        logic [3:0] went_offline_mask;
        logic [3:0] came_online_mask;
        logic       system_offline;
        logic       system_went_offline;
        logic       system_came_online;
        logic [2:0] worst_level;
        logic [2:0] display_channel;
        logic       offline_led;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/hbtm_eval.sv]
// Check evaluation: per-channel age compare, severity reduction, transitions.
`default_nettype none

module hbtm_eval (
    input  wire logic [hbtm_pkg::TIME_W-1:0]       now_ms,
    input  wire hbtm_pkg::time_vec_t               last_seen,
    input  wire logic [hbtm_pkg::REG_CHANNELS-1:0] exists,
    input  wire hbtm_pkg::cfg_t                    cfg,
    input  wire logic [hbtm_pkg::REG_CHANNELS-1:0] prev_online,
    input  wire logic                              sys_prev_online,
    output hbtm_pkg::result_t                      result,
    output logic [hbtm_pkg::REG_CHANNELS-1:0]      prev_online_next,
    output logic                                   sys_prev_online_next
);

    logic [hbtm_pkg::REG_CHANNELS-1:0] offline;
    logic [hbtm_pkg::REG_CHANNELS-1:0][hbtm_pkg::LEVEL_W-1:0] level;
    logic [2:0] worst;
    logic [2:0] display;
    logic       protect;

    // Compare each channel's wrapped age against its timeout
    always_comb
    begin
        for (int i = 0; i < hbtm_pkg::REG_CHANNELS; i++)
        begin
            level[i]   = cfg.channel_levels[2*i +: 2];
            offline[i] = exists[i] && cfg.enable_mask[i+1] &&
                         ((now_ms - last_seen[i]) > cfg.timeouts[i]);
        end
    end

    // Find the most severe level and the channel to display
    always_comb
    begin
        worst   = hbtm_pkg::LEVEL_NONE;
        display = 3'd0;
        for (int i = 0; i < hbtm_pkg::REG_CHANNELS; i++)
        begin
            if (offline[i] && ({1'b0, level[i]} < worst))
            begin
                worst = {1'b0, level[i]};
            end
            if (offline[i] && (level[i] <= cfg.warning_level))
            begin
                display = 3'(i + 1);
            end
        end
    end

    assign protect = cfg.enable_mask[0] && (worst == {1'b0, cfg.fatal_level});

    // Build the result and the next transition state
    always_comb
    begin
        result.offline_mask    = offline;
        result.worst_level     = worst;
        result.display_channel = display;
        result.offline_led     = (display != 3'd0);
        if (protect)
        begin
            result.system_offline      = 1'b1;
            result.system_went_offline = sys_prev_online;
            result.system_came_online  = 1'b0;
            result.went_offline_mask   = '0;
            result.came_online_mask    = '0;
            sys_prev_online_next       = 1'b0;
            prev_online_next           = prev_online;
        end
        else
        begin
            result.system_offline      = 1'b0;
            result.system_went_offline = 1'b0;
            result.system_came_online  = !sys_prev_online;
            result.went_offline_mask   = offline & prev_online & exists;
            result.came_online_mask    = ~offline & ~prev_online & exists;
            sys_prev_online_next       = 1'b1;
            prev_online_next           = ~offline;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/heartbeat_timeout_monitor.sv]
// Flow: a check word accepted into the input register is then loaded into the result register,
// which raises out_valid; a heartbeat gives no result.
// Throughput: one word per cycle; a check that meets a full result register waits in the
// input register and holds off the words behind it until the result is taken.
// Reset clears all time stamps to zero, marks every channel and the system offline,
// and loads the configuration registers with their default values.
`default_nettype none

module heartbeat_timeout_monitor #(
    parameter int CHANNELS = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              opcode,
    input  wire logic [hbtm_pkg::CHAN_W-1:0]       channel,
    input  wire logic [hbtm_pkg::TIME_W-1:0]       now_ms,
    // result channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [3:0]                             offline_mask,
    output logic [3:0]                             went_offline_mask,
    output logic [3:0]                             came_online_mask,
    output logic                                   system_offline,
    output logic                                   system_went_offline,
    output logic                                   system_came_online,
    output logic [2:0]                             worst_level,
    output logic [2:0]                             display_channel,
    output logic                                   offline_led,
    // configuration channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [hbtm_pkg::CIDX_W-1:0]       cfg_index,
    input  wire logic [hbtm_pkg::CDATA_W-1:0]      cfg_data
);

    // Channels that are both present and have registers
    localparam int ACTIVE = (CHANNELS < hbtm_pkg::REG_CHANNELS) ?
                            CHANNELS : hbtm_pkg::REG_CHANNELS;

    // Configuration registers
    hbtm_pkg::cfg_t cfg_reg;

    // Input stage
    logic                          s1_valid_reg;
    logic                          s1_opcode_reg;
    logic [hbtm_pkg::CHAN_W-1:0]   s1_channel_reg;
    logic [hbtm_pkg::TIME_W-1:0]   s1_now_reg;

    // Channel state
    logic [ACTIVE-1:0][hbtm_pkg::TIME_W-1:0] last_seen_reg;
    logic [ACTIVE-1:0]                       prev_online_reg;
    logic                                    sys_prev_online_reg;

    // Result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    hbtm_pkg::result_t res_reg;

    hbtm_pkg::time_vec_t                 last_seen_pad;
    logic [hbtm_pkg::REG_CHANNELS-1:0]   exists;
    logic [hbtm_pkg::REG_CHANNELS-1:0]   prev_online_pad;
    logic [hbtm_pkg::REG_CHANNELS-1:0]   prev_online_next;
    logic                                sys_prev_online_next;
    hbtm_pkg::result_t                   res_next;

    logic in_fire;
    logic s1_is_check;
    logic s1_is_hb;
    logic out_load;
    logic s1_advance;

    // Handshake control
    assign s1_is_check = s1_valid_reg && (s1_opcode_reg == hbtm_pkg::OP_CHECK);
    assign s1_is_hb    = s1_valid_reg && (s1_opcode_reg == hbtm_pkg::OP_HEARTBEAT);
    assign out_load    = s1_is_check && (!out_valid_reg || out_ready);
    assign s1_advance  = s1_is_hb || out_load;
    assign in_ready    = !s1_valid_reg || s1_advance;
    assign in_fire     = in_valid && in_ready;
    assign cfg_ready   = 1'b1;

    // Hold or advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_opcode_reg  <= opcode;
            s1_channel_reg <= channel;
            s1_now_reg     <= now_ms;
        end
    end

    // Write configuration registers; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask    <= hbtm_pkg::RST_ENABLE_MASK;
            cfg_reg.channel_levels <= hbtm_pkg::RST_CHANNEL_LEVELS;
            cfg_reg.timeouts       <= {hbtm_pkg::REG_CHANNELS{hbtm_pkg::RST_TIMEOUT}};
            cfg_reg.warning_level  <= hbtm_pkg::RST_WARNING_LEVEL;
            cfg_reg.fatal_level    <= hbtm_pkg::RST_FATAL_LEVEL;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hbtm_pkg::CFG_ENABLE_MASK:    cfg_reg.enable_mask    <= cfg_data[4:0];
                hbtm_pkg::CFG_CHANNEL_LEVELS: cfg_reg.channel_levels <= cfg_data[7:0];
                hbtm_pkg::CFG_TIMEOUT_ONE:    cfg_reg.timeouts[0]    <= cfg_data;
                hbtm_pkg::CFG_TIMEOUT_TWO:    cfg_reg.timeouts[1]    <= cfg_data;
                hbtm_pkg::CFG_TIMEOUT_THREE:  cfg_reg.timeouts[2]    <= cfg_data;
                hbtm_pkg::CFG_TIMEOUT_FOUR:   cfg_reg.timeouts[3]    <= cfg_data;
                hbtm_pkg::CFG_WARNING_LEVEL:  cfg_reg.warning_level  <= cfg_data[1:0];
                hbtm_pkg::CFG_FATAL_LEVEL:    cfg_reg.fatal_level    <= cfg_data[1:0];
                default:                      ;
            endcase
        end
    end

    // Per-channel state: time stamp on heartbeat, transition mark on check
    for (genvar g = 0; g < hbtm_pkg::REG_CHANNELS; g++)
    begin : g_chan
        if (g < ACTIVE)
        begin : g_live
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    last_seen_reg[g]   <= '0;
                    prev_online_reg[g] <= 1'b0;
                end
                else
                begin
                    if (s1_is_hb && (s1_channel_reg == hbtm_pkg::CHAN_W'(g + 1)))
                    begin
                        last_seen_reg[g] <= s1_now_reg;
                    end
                    if (out_load)
                    begin
                        prev_online_reg[g] <= prev_online_next[g];
                    end
                end
            end
            assign last_seen_pad[g]   = last_seen_reg[g];
            assign prev_online_pad[g] = prev_online_reg[g];
            assign exists[g]          = 1'b1;
        end
        else
        begin : g_absent
            assign last_seen_pad[g]   = '0;
            assign prev_online_pad[g] = 1'b0;
            assign exists[g]          = 1'b0;
        end
    end

    // Evaluate a check
    hbtm_eval u_eval (
        .now_ms               (s1_now_reg),
        .last_seen            (last_seen_pad),
        .exists               (exists),
        .cfg                  (cfg_reg),
        .prev_online          (prev_online_pad),
        .sys_prev_online      (sys_prev_online_reg),
        .result               (res_next),
        .prev_online_next     (prev_online_next),
        .sys_prev_online_next (sys_prev_online_next)
    );

    // System protect state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_prev_online_reg <= 1'b0;
        end
        else if (out_load)
        begin
            sys_prev_online_reg <= sys_prev_online_next;
        end
    end

    // Result register
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    // Drive result ports
    assign out_valid           = out_valid_reg;
    assign offline_mask        = res_reg.offline_mask;
    assign went_offline_mask   = res_reg.went_offline_mask;
    assign came_online_mask    = res_reg.came_online_mask;
    assign system_offline      = res_reg.system_offline;
    assign system_went_offline = res_reg.system_went_offline;
    assign system_came_online  = res_reg.system_came_online;
    assign worst_level         = res_reg.worst_level;
    assign display_channel     = res_reg.display_channel;
    assign offline_led         = res_reg.offline_led;

endmodule

`default_nettype wire

[bench/heartbeat_timeout_monitor_tb.sv]
// Self-checking testbench for the heartbeat timeout monitor: random stimulus against a scoreboard.
`timescale 1ns / 1ps

module heartbeat_timeout_monitor_tb;

    import hbtm_pkg::*;

    localparam int NUM_CHANNELS = 4;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 160;
    localparam logic [CIDX_W-1:0] CFG_UNUSED_INDEX = 4'd15;

    // Tracks time stamps and online marks, predicts every check status word
    class liveness_scoreboard;
        logic [4:0]        enables;
        logic [7:0]        levels;
        logic [TIME_W-1:0] limits [REG_CHANNELS];
        logic [1:0]        warn_lvl;
        logic [1:0]        fatal_lvl;
        logic [TIME_W-1:0] stamps [REG_CHANNELS];
        bit                chan_up [REG_CHANNELS];
        bit                sys_up;
        result_t           status_due [$];
        int                mismatches;

        function new();
            enables = RST_ENABLE_MASK;
            levels = RST_CHANNEL_LEVELS;
            warn_lvl = RST_WARNING_LEVEL;
            fatal_lvl = RST_FATAL_LEVEL;
            for (int i = 0; i < REG_CHANNELS; i++)
            begin
                limits[i] = RST_TIMEOUT;
                stamps[i] = '0;
                chan_up[i] = 1'b0;
            end
            sys_up = 1'b0;
            mismatches = 0;
        endfunction

        function void note_register(logic [CIDX_W-1:0] idx, logic [CDATA_W-1:0] data);
            case (idx)
                CFG_ENABLE_MASK:    enables = data[4:0];
                CFG_CHANNEL_LEVELS: levels = data[7:0];
                CFG_TIMEOUT_ONE:    limits[0] = data;
                CFG_TIMEOUT_TWO:    limits[1] = data;
                CFG_TIMEOUT_THREE:  limits[2] = data;
                CFG_TIMEOUT_FOUR:   limits[3] = data;
                CFG_WARNING_LEVEL:  warn_lvl = data[1:0];
                CFG_FATAL_LEVEL:    fatal_lvl = data[1:0];
                default:            ;
            endcase
        endfunction

        // Store a heartbeat, or work out the status word a check produces
        function void accept_word(logic op, logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] t_ms);
            result_t           r;
            bit                down [REG_CHANNELS];
            logic [TIME_W-1:0] age;
            logic [2:0]        worst;
            logic [1:0]        lvl;
            if (op == OP_HEARTBEAT)
            begin
                if (ch >= 1 && ch <= NUM_CHANNELS)
                    stamps[2'(ch - 3'd1)] = t_ms;
                return;
            end
            r = '0;
            worst = LEVEL_NONE;
            for (int i = 0; i < REG_CHANNELS; i++)
            begin
                age = t_ms - stamps[i];
                lvl = levels[2 * i +: 2];
                down[i] = enables[i + 1] && (age > limits[i]);
                if (down[i])
                begin
                    r.offline_mask[i] = 1'b1;
                    if ({1'b0, lvl} < worst)
                        worst = {1'b0, lvl};
                    if (lvl <= warn_lvl)
                        r.display_channel = 3'(i + 1);
                end
            end
            // Protect trip freezes the per-channel marks
            if (worst == {1'b0, fatal_lvl} && enables[0])
            begin
                r.system_offline = 1'b1;
                r.system_went_offline = sys_up;
                sys_up = 1'b0;
            end
            else
            begin
                r.system_came_online = !sys_up;
                sys_up = 1'b1;
                for (int i = 0; i < REG_CHANNELS; i++)
                begin
                    r.went_offline_mask[i] = down[i] && chan_up[i];
                    r.came_online_mask[i] = !down[i] && !chan_up[i];
                    chan_up[i] = !down[i];
                end
            end
            r.worst_level = worst;
            r.offline_led = (r.display_channel != 0);
            status_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [3:0] want, logic [3:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
            end
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (status_due.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: status word with nothing expected, expected none actual %h",
                         $time, got);
                return;
            end
            want = status_due.pop_front();
            compare_field("offline_mask", want.offline_mask, got.offline_mask);
            compare_field("went_offline_mask", want.went_offline_mask, got.went_offline_mask);
            compare_field("came_online_mask", want.came_online_mask, got.came_online_mask);
            compare_field("system_offline", 4'(want.system_offline),
                          4'(got.system_offline));
            compare_field("system_went_offline", 4'(want.system_went_offline),
                          4'(got.system_went_offline));
            compare_field("system_came_online", 4'(want.system_came_online),
                          4'(got.system_came_online));
            compare_field("worst_level", 4'(want.worst_level), 4'(got.worst_level));
            compare_field("display_channel", 4'(want.display_channel),
                          4'(got.display_channel));
            compare_field("offline_led", 4'(want.offline_led), 4'(got.offline_led));
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                opcode = OP_HEARTBEAT;
    logic [CHAN_W-1:0]   channel = '0;
    logic [TIME_W-1:0]   now_ms = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [3:0]          offline_mask;
    logic [3:0]          went_offline_mask;
    logic [3:0]          came_online_mask;
    logic                system_offline;
    logic                system_went_offline;
    logic                system_came_online;
    logic [2:0]          worst_level;
    logic [2:0]          display_channel;
    logic                offline_led;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CDATA_W-1:0]  cfg_data = '0;

    liveness_scoreboard  book;
    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    bit                  holdoff_req = 1'b0;
    int                  holdoff_left = 0;
    int                  quiet_cycles = 0;
    int unsigned         step_ms = 10;
    logic [TIME_W-1:0]   clock_ms = '0;

    heartbeat_timeout_monitor #(
        .CHANNELS (NUM_CHANNELS)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .opcode              (opcode),
        .channel             (channel),
        .now_ms              (now_ms),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .offline_mask        (offline_mask),
        .went_offline_mask   (went_offline_mask),
        .came_online_mask    (came_online_mask),
        .system_offline      (system_offline),
        .system_went_offline (system_went_offline),
        .system_came_online  (system_came_online),
        .worst_level         (worst_level),
        .display_channel     (display_channel),
        .offline_led         (offline_led),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Record every word that crosses a handshake
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            book.note_register(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
            book.accept_word(opcode, channel, now_ms);
        if (rst_n && out_valid && out_ready)
            book.check_status(result_t'({offline_mask, went_offline_mask, came_online_mask,
                                         system_offline, system_went_offline,
                                         system_came_online, worst_level, display_channel,
                                         offline_led}));
    end

    // Drive the result side: random stalls, or a long hold-off on request
    always @(posedge clk)
    begin
        if (holdoff_req)
        begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_req = 1'b0;
        end
        if (holdoff_left > 0)
        begin
            holdoff_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Drop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one word, idling first at random, and hold it until accepted
    task automatic send_word(input logic op, input logic [CHAN_W-1:0] ch,
                             input logic [TIME_W-1:0] t_ms);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        opcode <= op;
        channel <= ch;
        now_ms <= t_ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Drain all pending status words, then let the last word land
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_phase(input int p);
        logic [TIME_W-1:0] limit;
        write_reg(CFG_ENABLE_MASK, (p == 0) ? 32'h1F : (p == 5) ? 32'h0 : $urandom);
        write_reg(CFG_CHANNEL_LEVELS, (p == 1) ? 32'h0 : (p == 2) ? 32'hFF : $urandom);
        for (int c = 0; c < REG_CHANNELS; c++)
        begin
            case ($urandom_range(7))
                0:       limit = '0;
                1:       limit = '1;
                default: limit = $urandom_range(8 * step_ms);
            endcase
            write_reg(CFG_TIMEOUT_ONE + CIDX_W'(c), limit);
        end
        write_reg(CFG_WARNING_LEVEL, (p == 3) ? 32'd0 : (p == 4) ? 32'd3 : $urandom);
        write_reg(CFG_FATAL_LEVEL, (p == 3) ? 32'd3 : (p == 4) ? 32'd0 : $urandom);
        write_reg(CFG_UNUSED_INDEX - CIDX_W'($urandom_range(7)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Mostly heartbeats and checks on a moving clock, some noise and bad channels
    task automatic random_word();
        int                pick;
        logic [CHAN_W-1:0] bad_ch;
        pick = $urandom_range(99);
        clock_ms += $urandom_range(step_ms);
        if (pick < 5)
            send_word($urandom_range(1) ? OP_CHECK : OP_HEARTBEAT, CHAN_W'($urandom_range(7)),
                      $urandom);
        else if (pick < 9)
        begin
            bad_ch = CHAN_W'($urandom_range(3));
            if (bad_ch != 0)
                bad_ch = bad_ch + 3'd4;
            send_word(OP_HEARTBEAT, bad_ch, clock_ms);
        end
        else if (pick < 55)
            send_word(OP_HEARTBEAT, CHAN_W'($urandom_range(1, NUM_CHANNELS)), clock_ms);
        else
            send_word(OP_CHECK, CHAN_W'($urandom_range(7)), clock_ms);
    endtask

    initial
    begin
        book = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: all channels disabled, first check brings them online
        send_word(OP_CHECK, 3'd0, 32'd0);
        send_word(OP_HEARTBEAT, 3'd0, 32'd5);
        send_word(OP_HEARTBEAT, 3'd7, 32'd5);
        send_word(OP_HEARTBEAT, 3'd5, 32'd5);
        send_word(OP_CHECK, 3'd7, 32'hFFFF_FFFF);
        settle();

        // All enabled with protect, one level per channel, extreme timeouts
        write_reg(CFG_ENABLE_MASK, 32'hFFFF_FFFF);
        write_reg(CFG_CHANNEL_LEVELS, 32'hE4);
        write_reg(CFG_TIMEOUT_ONE, 32'd100);
        write_reg(CFG_TIMEOUT_TWO, 32'd0);
        write_reg(CFG_TIMEOUT_THREE, 32'hFFFF_FFFF);
        write_reg(CFG_TIMEOUT_FOUR, 32'd50);
        write_reg(CFG_WARNING_LEVEL, 32'd1);
        write_reg(CFG_FATAL_LEVEL, 32'd0);
        write_reg(CFG_UNUSED_INDEX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        for (int c = 1; c <= NUM_CHANNELS; c++)
            send_word(OP_HEARTBEAT, CHAN_W'(c), 32'd1000);
        send_word(OP_CHECK, 3'd0, 32'd1000);
        send_word(OP_CHECK, 3'd0, 32'd1001);
        send_word(OP_CHECK, 3'd0, 32'd1051);
        // Channel one at the fatal level trips protect
        send_word(OP_CHECK, 3'd0, 32'd1101);
        send_word(OP_HEARTBEAT, 3'd1, 32'd1101);
        send_word(OP_CHECK, 3'd0, 32'd1102);
        send_word(OP_CHECK, 3'd0, 32'd0);
        // Age taken across the wrap of the time stamp
        send_word(OP_HEARTBEAT, 3'd1, 32'hFFFF_FFF0);
        send_word(OP_CHECK, 3'd0, 32'h10);
        settle();
        write_reg(CFG_ENABLE_MASK, 32'h1E);
        write_reg(CFG_FATAL_LEVEL, 32'd3);
        cfg_valid <= 1'b0;
        send_word(OP_CHECK, 3'd0, 32'h1000);

        // Random phases: new settings, idling pattern and time scale each
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 51; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 51; end
                default: begin send_idle_pct = 26; stall_pct = 26; end
            endcase
            case (p / 2)
                0:       step_ms = 3;
                1:       step_ms = 50;
                2:       step_ms = 1000;
                default: step_ms = 100000;
            endcase
            program_phase(p);
            if (p % 2 == 1)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(20 * step_ms);
            else
                clock_ms = $urandom;
            // Block the result side while checks keep coming
            if (p == 2)
                holdoff_req = 1'b1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                random_word();
        end

        settle();
        repeat (4) @(posedge clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
